FILE: hdl/epsm_pkg.sv
`default_nettype none
package epsm_pkg;

   typedef logic [7:0] sym_type;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TEXT = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   // per-request side information carried along the compare pipeline
   typedef struct packed {
      logic        is_text;
      logic        fill_ok;
      logic [1:0]  status;
      logic [31:0] start;
   } info_type;

endpackage
`default_nettype wire

FILE: hdl/epsm_cell.sv
`default_nettype none
module epsm_cell #(
   parameter int INDEX = 0,
   parameter int LW    = 8
) (
   input  wire logic             clock,
   input  wire logic             update,
   input  wire logic             shift_text,
   input  wire logic             shift_pat,
   input  wire logic [LW-1:0]    len_next,
   input  wire epsm_pkg::sym_type text_prev,
   input  wire epsm_pkg::sym_type pat_prev,
   output      epsm_pkg::sym_type text_out,
   output      epsm_pkg::sym_type pat_out,
   output      logic             hit
);
   import epsm_pkg::*;

   sym_type text_ff, text_in;
   sym_type pat_ff, pat_in;
   logic    hit_ff, hit_in;

   always_comb begin
      text_in = shift_text ? text_prev : text_ff;
      pat_in  = shift_pat ? pat_prev : pat_ff;
      // cells past the pattern end always agree
      hit_in  = (len_next <= LW'(INDEX)) || (text_in == pat_in);
   end

   always_ff @(posedge clock) begin
      if (update) begin
         text_ff <= text_in;
         pat_ff  <= pat_in;
         hit_ff  <= hit_in;
      end
   end

   assign text_out = text_ff;
   assign pat_out  = pat_ff;
   assign hit      = hit_ff;

endmodule
`default_nettype wire

FILE: hdl/epsm_reduce.sv
`default_nettype none
module epsm_reduce #(
   parameter int N_CELLS = 128,
   parameter int GROUP   = 32,
   parameter int N_GRP   = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 a_valid,
   input  wire epsm_pkg::info_type   a_info,
   input  wire logic [N_CELLS-1:0]   hits,
   output      logic                 b_valid,
   output      epsm_pkg::info_type   b_info,
   output      logic [N_GRP-1:0]     b_groups
);
   import epsm_pkg::*;

   logic [N_GRP-1:0] groups_ff, groups_in;
   logic             valid_ff;
   info_type         info_ff;

   genvar g, j;
   generate
      for (g = 0; g < N_GRP; g++) begin : gen_grp
         logic [GROUP-1:0] slice;
         for (j = 0; j < GROUP; j++) begin : gen_bit
            if (g * GROUP + j < N_CELLS) begin : gen_real
               assign slice[j] = hits[g * GROUP + j];
            end else begin : gen_pad
               assign slice[j] = 1'b1;
            end
         end
         assign groups_in[g] = &slice;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         groups_ff <= groups_in;
         info_ff   <= a_info;
      end
   end

   assign b_valid  = valid_ff;
   assign b_info   = info_ff;
   assign b_groups = groups_ff;

endmodule
`default_nettype wire

FILE: hdl/exact_pattern_stream_matcher.sv
// throughput: one request per cycle while no response waits in the output register
// the cell row updates on every accepted request, and the compare result goes
// through a registered two-level and-tree to the stage b and output registers
// reset: pattern empty, text position and window fill cleared, pipeline empty
// pattern and window byte registers are not cleared and need no clearing pass
`default_nettype none
module exact_pattern_stream_matcher #(
   parameter int MAX_PATTERN = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic                 req_type,
   input  wire epsm_pkg::sym_type    req_symbol,
   input  wire logic                 req_first,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic                 rsp_match_found,
   output      logic [31:0]          rsp_match_start,
   output      logic [1:0]           rsp_status
);
   import epsm_pkg::*;

   localparam int LW    = $clog2(MAX_PATTERN + 1);
   localparam int GROUP = 32;
   localparam int N_GRP = (MAX_PATTERN + GROUP - 1) / GROUP;
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);
   localparam logic [31:0]   POS_MAX = 32'hFFFF_FFFF;

   // global pipeline advance: output register empty or being drained
   logic enable;
   logic accept;

   // sequencing state
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [31:0]   count_ff, count_in;

   // stage a: cell row just updated
   logic     a_valid_ff, a_valid_in;
   info_type a_info_ff, a_info_in;

   // stage b: group results
   logic             b_valid;
   info_type         b_info;
   logic [N_GRP-1:0] b_groups;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff, found_in;
   logic [31:0] start_ff, start_in;
   logic [1:0]  status_ff, status_in;

   // request decode
   logic          is_text;
   logic          pat_full;
   logic          shift_pat;
   logic          shift_text;
   logic [LW-1:0] fill_base;
   logic [31:0]   pos;

   assign enable = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && enable;
   assign req_ready = enable;

   always_comb begin
      is_text    = (req_type == REQ_TEXT);
      pat_full   = !req_first && (len_ff == LEN_MAX);
      shift_pat  = accept && !is_text && !pat_full;
      shift_text = accept && is_text;
      fill_base  = req_first ? '0 : fill_ff;
      pos        = req_first ? '0 : count_ff;

      len_in   = len_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (accept && !is_text) begin
         // a first byte empties the pattern before it is appended
         if (req_first) begin
            len_in = LW'(1);
         end else if (!pat_full) begin
            len_in = len_ff + LW'(1);
         end
      end
      if (shift_text) begin
         fill_in  = (fill_base < LEN_MAX) ? fill_base + LW'(1) : fill_base;
         // position saturates at the top of its range
         count_in = (pos == POS_MAX) ? pos : pos + 32'd1;
      end

      a_valid_in        = accept;
      a_info_in.is_text = is_text;
      a_info_in.fill_ok = (len_ff != '0) && (fill_in >= len_ff);
      a_info_in.start   = pos - 32'(len_ff) + 32'd1;
      if (!is_text) begin
         a_info_in.status = pat_full ? ST_DROPPED : ST_OK;
      end else begin
         a_info_in.status = (len_ff == '0) ? ST_EMPTY : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         fill_ff    <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         if (enable) begin
            a_valid_ff <= a_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_info_ff <= a_info_in;
      end
   end

   // row of cells: cell k holds the k-th newest text byte and the pattern byte
   // that lines up with it, so each compare is local to its cell
   sym_type              text_chain [MAX_PATTERN+1];
   sym_type              pat_chain  [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] hits;

   assign text_chain[0] = req_symbol;
   assign pat_chain[0]  = req_symbol;

   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : gen_cell
         epsm_cell #(
            .INDEX (k),
            .LW    (LW)
         ) u_cell (
            .clock      (clock),
            .update     (accept),
            .shift_text (shift_text),
            .shift_pat  (shift_pat),
            .len_next   (len_in),
            .text_prev  (text_chain[k]),
            .pat_prev   (pat_chain[k]),
            .text_out   (text_chain[k+1]),
            .pat_out    (pat_chain[k+1]),
            .hit        (hits[k])
         );
      end
   endgenerate

   epsm_reduce #(
      .N_CELLS (MAX_PATTERN),
      .GROUP   (GROUP),
      .N_GRP   (N_GRP)
   ) u_reduce (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .a_valid  (a_valid_ff),
      .a_info   (a_info_ff),
      .hits     (hits),
      .b_valid  (b_valid),
      .b_info   (b_info),
      .b_groups (b_groups)
   );

   // final and over the groups, only for text requests with enough window
   always_comb begin
      rsp_valid_in = b_valid;
      found_in     = b_info.is_text && b_info.fill_ok && (&b_groups);
      start_in     = found_in ? b_info.start : 32'd0;
      status_in    = b_info.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         found_ff  <= found_in;
         start_ff  <= start_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = found_ff;
   assign rsp_match_start = start_ff;
   assign rsp_status      = status_ff;

   // a match is only reported with an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_status == ST_OK)
      else $error("match reported with non-ok status");

   // pattern length and window fill never exceed capacity
   assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_MAX) && (fill_ff <= LEN_MAX))
      else $error("length or fill beyond capacity");

   // a dropped pattern byte leaves the pattern length alone
   assert property (@(posedge clock) disable iff (reset)
      accept && !is_text && pat_full |=> len_ff == $past(len_ff))
      else $error("dropped byte changed pattern length");

   // a saturated position stays saturated until the text restarts
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == POS_MAX) && !(accept && is_text && req_first) |=> count_ff == POS_MAX)
      else $error("saturated position moved");

   // the pipeline stalls as a whole while the response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(b_valid) && $stable(a_valid_ff))
      else $error("pipeline advanced during stall");

endmodule
`default_nettype wire

FILE: tb/sv/exact_pattern_stream_matcher_tb.sv
`timescale 1ns / 100ps

module exact_pattern_stream_matcher_tb;

   import epsm_pkg::*;

   localparam int PATTERN_CAPACITY = 128;
   localparam int RANDOM_ITEMS     = 30;      // random items spread over the idling phases
   localparam int STALL_CYCLES     = 80;      // long receiver hold-off
   localparam int TAIL_CYCLES      = 8;       // idle cycles for a stray response to surface
   localparam int CYCLE_LIMIT      = 200_000; // watchdog bound on the whole run

   // one response as the block should produce it
   typedef struct packed {
      logic        found;
      logic [31:0] start;
      logic [1:0]  status;
   } match_result_type;

   // scoreboard: mirrors the pattern and text window, queues the predicted responses
   class match_scoreboard;
      logic [7:0]       pattern_bytes [PATTERN_CAPACITY];
      logic [7:0]       window_bytes  [PATTERN_CAPACITY];
      int unsigned      pattern_len;
      int unsigned      window_fill;
      logic [31:0]      text_pos;
      match_result_type pending [$];
      int               errors;
      int               hit_count;
      int               drops;
      int               empties;
      int               checked;

      function new();
         foreach (window_bytes[k]) window_bytes[k] = 8'h00;
         foreach (pattern_bytes[k]) pattern_bytes[k] = 8'h00;
         pattern_len = 0;
         window_fill = 0;
         text_pos    = 32'd0;
         errors      = 0;
         hit_count   = 0;
         drops       = 0;
         empties     = 0;
         checked     = 0;
      endfunction

      function void note_request(logic kind, logic [7:0] sym, logic first);
         match_result_type want;
         int unsigned      k;
         logic [31:0]      pos;
         bit               hit;
         want.found  = 1'b0;
         want.start  = 32'd0;
         want.status = ST_OK;
         if (kind == REQ_LOAD) begin
            if (first) pattern_len = 0;
            if (pattern_len < PATTERN_CAPACITY) begin
               pattern_bytes[pattern_len] = sym;
               pattern_len++;
            end else begin
               want.status = ST_DROPPED;
               drops++;
            end
         end else begin
            if (first) begin
               text_pos    = 32'd0;
               window_fill = 0;
            end
            for (k = PATTERN_CAPACITY - 1; k > 0; k--) window_bytes[k] = window_bytes[k - 1];
            window_bytes[0] = sym;
            if (window_fill < PATTERN_CAPACITY) window_fill++;
            pos = text_pos;
            if (text_pos != 32'hFFFF_FFFF) text_pos++;
            if (pattern_len == 0) begin
               want.status = ST_EMPTY;
               empties++;
            end else if (window_fill >= pattern_len) begin
               hit = 1'b1;
               for (k = 0; k < pattern_len; k++)
                  if (window_bytes[k] != pattern_bytes[pattern_len - 1 - k]) hit = 1'b0;
               if (hit) begin
                  want.found = 1'b1;
                  want.start = pos - pattern_len + 1;
                  hit_count++;
               end
            end
         end
         pending.insert(pending.size(), want);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= 30)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_response(logic found, logic [31:0] start, logic [1:0] status);
         match_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: extra response, expected none actual found %0d start %0d status %0d",
                        $time, found, start, status);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (found !== want.found) report("match_found", 32'(want.found), 32'(found));
         if (start !== want.start) report("match_start", want.start, start);
         if (status !== want.status) report("status", 32'(want.status), 32'(status));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   logic    req_type;
   sym_type req_symbol;
   logic    req_first;
   logic    rsp_valid;
   logic    rsp_ready;
   logic    rsp_match_found;
   logic [31:0] rsp_match_start;
   logic [1:0]  rsp_status;

   match_scoreboard sb;

   // idling odds in percent per cycle, set per phase by the stimulus
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int cycle_count = 0;
   bit hold_request;   // stimulus asks the receiver for one long hold-off
   int hold_left;

   // stimulus-side copy of the pattern, used to plant occurrences in the text
   logic [7:0] loaded_pattern [$];

   exact_pattern_stream_matcher #(
      .MAX_PATTERN(PATTERN_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_symbol(req_symbol),
      .req_first(req_first),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match_found(rsp_match_found),
      .rsp_match_start(rsp_match_start),
      .rsp_status(rsp_status)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("exact_pattern_stream_matcher_tb NOT OK");
         $finish;
      end
   end

   // monitor: both handshakes sampled at the edge that completes them
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_type, req_symbol, req_first);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_match_found, rsp_match_start, rsp_status);
      end
   end

   // receiver: random back-pressure, plus one long hold-off counted here
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = STALL_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
         @(posedge clock);
      end
   end

   // offer one request, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_request(input logic kind, input logic [7:0] sym, input logic first);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_symbol <= sym;
      req_first  <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (kind == REQ_LOAD) begin
         if (first) loaded_pattern.delete();
         if (loaded_pattern.size() < PATTERN_CAPACITY)
            loaded_pattern.insert(loaded_pattern.size(), sym);
      end
   endtask

   // sender pauses until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() > 0) @(posedge clock);
   endtask

   // short pattern over a two-symbol alphabet, then text with planted copies
   task automatic run_pattern_episode();
      int         plen;
      int         tlen;
      int         i;
      bit         fresh;
      logic [7:0] sym_a;
      logic [7:0] sym_b;
      logic [7:0] sym;
      plen  = $urandom_range(1, 6);
      sym_a = 8'($urandom_range(0, 255));
      sym_b = sym_a ^ (8'h01 << $urandom_range(0, 7));   // near-alike bytes
      for (i = 0; i < plen; i++)
         send_request(REQ_LOAD, $urandom_range(0, 1) ? sym_a : sym_b, i == 0);
      tlen  = $urandom_range(8, 30);
      fresh = ($urandom_range(0, 2) == 0);   // sometimes restart the text position
      i     = 0;
      while (i < tlen) begin
         if ($urandom_range(0, 3) == 0) begin
            // plant a full occurrence, often overlapping what came before
            foreach (loaded_pattern[j]) begin
               send_request(REQ_TEXT, loaded_pattern[j], fresh);
               fresh = 1'b0;
            end
            i += loaded_pattern.size();
         end else begin
            if ($urandom_range(0, 9) == 0) sym = 8'($urandom_range(0, 255));
            else sym = $urandom_range(0, 1) ? sym_a : sym_b;
            send_request(REQ_TEXT, sym, fresh);
            fresh = 1'b0;
            i++;
         end
      end
   endtask

   // full pattern, overflow bytes, then a corrupted and an exact copy in the text
   task automatic run_capacity_episode();
      int         i;
      int         bad_at;
      logic [7:0] sym;
      for (i = 0; i < PATTERN_CAPACITY; i++)
         send_request(REQ_LOAD, 8'($urandom_range(0, 255)), i == 0);
      repeat ($urandom_range(1, 3)) send_request(REQ_LOAD, 8'($urandom_range(0, 255)), 1'b0);
      bad_at = $urandom_range(0, PATTERN_CAPACITY - 1);
      for (i = 0; i < PATTERN_CAPACITY; i++) begin
         sym = loaded_pattern[i];
         if (i == bad_at) sym = sym ^ (8'h01 << $urandom_range(0, 7));
         send_request(REQ_TEXT, sym, i == 0);
      end
      foreach (loaded_pattern[j]) send_request(REQ_TEXT, loaded_pattern[j], 1'b0);
   endtask

   // main stimulus
   initial begin
      int phase;
      int phase_end;
      int episode;
      int r;
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_LOAD;
      req_symbol   = 8'h00;
      req_first    = 1'b0;
      hold_request = 1'b0;
      items_sent   = 0;
      send_idle_pct = 6;
      recv_idle_pct = 83;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: text with no pattern loaded, at both byte extremes
      send_request(REQ_TEXT, 8'h00, 1'b1);
      send_request(REQ_TEXT, 8'hFF, 1'b0);
      // pattern loaded mid-text is compared against the bytes already seen
      send_request(REQ_LOAD, 8'hFF, 1'b1);
      send_request(REQ_LOAD, 8'h00, 1'b0);
      send_request(REQ_TEXT, 8'h00, 1'b0);
      send_request(REQ_TEXT, 8'hFF, 1'b0);
      send_request(REQ_TEXT, 8'h00, 1'b0);
      send_request(REQ_TEXT, 8'hFF, 1'b0);
      // text restart empties the window
      send_request(REQ_TEXT, 8'h00, 1'b1);
      // single-byte pattern, back-to-back occurrences
      send_request(REQ_LOAD, 8'hAA, 1'b1);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      // appending to the pattern without a restart
      send_request(REQ_LOAD, 8'hAA, 1'b0);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      // overlapping occurrences of a three-byte pattern
      send_request(REQ_LOAD, 8'h55, 1'b1);
      send_request(REQ_LOAD, 8'hAA, 1'b0);
      send_request(REQ_LOAD, 8'h55, 1'b0);
      send_request(REQ_TEXT, 8'h55, 1'b1);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      send_request(REQ_TEXT, 8'h55, 1'b0);
      send_request(REQ_TEXT, 8'hAA, 1'b0);
      send_request(REQ_TEXT, 8'h55, 1'b0);
      drain_responses();

      // random part in three idling phases
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_end = items_sent + RANDOM_ITEMS / 3;
         episode   = 0;
         while (items_sent < phase_end || (phase == 2 && episode < 2)) begin
            if (phase == 2 && episode == 0) begin
               // receiver stalls long while requests keep coming, so the block backs up
               hold_request = 1'b1;
               run_pattern_episode();
            end else if (phase == 2 && episode == 1) begin
               run_capacity_episode();
            end else begin
               r = $urandom_range(0, 99);
               if (r < 70) begin
                  run_pattern_episode();
               end else if (r < 82) begin
                  // extend the current pattern, then a little text
                  repeat ($urandom_range(1, 2))
                     send_request(REQ_LOAD, 8'($urandom_range(0, 255)), 1'b0);
                  foreach (loaded_pattern[j]) send_request(REQ_TEXT, loaded_pattern[j], 1'b0);
                  repeat ($urandom_range(1, 4))
                     send_request(REQ_TEXT, 8'($urandom_range(0, 255)), 1'b0);
               end else begin
                  // noise: anything the fields allow
                  repeat ($urandom_range(5, 15))
                     send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 4) == 0);
               end
            end
            episode++;
         end
         drain_responses();
      end

      // all stimulus accepted: let any stray response surface
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run: %0d requests, %0d checked, %0d matches, %0d drops, %0d with no pattern",
               items_sent, sb.checked, sb.hit_count, sb.drops, sb.empties);
      $display("idling 6/83, 83/6, none; one %0d-cycle response stall; full-size pattern",
               STALL_CYCLES);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("exact_pattern_stream_matcher_tb OK");
      end else begin
         $display("%0d errors, %0d responses missing", sb.errors, sb.pending.size());
         $display("exact_pattern_stream_matcher_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: exact_pattern_stream_matcher.f
hdl/epsm_pkg.sv
hdl/epsm_cell.sv
hdl/epsm_reduce.sv
hdl/exact_pattern_stream_matcher.sv
tb/sv/exact_pattern_stream_matcher_tb.sv
